### rtl/gfp_pkg.sv
// ----------------------------------------------------------------------------
// gfp_pkg
// Shared types, constants and helpers of the first-fit rectangle placer.
// ----------------------------------------------------------------------------
package gfp_pkg;

    localparam int MAX_COLUMNS_DEF = 16;
    localparam int MAX_ROWS_DEF    = 16;
    localparam int ID_BITS_DEF     = 8;

    // wide enough for any grid dimension up to 64 plus a carry
    localparam int DIM_W = 7;

    typedef enum logic [1:0] {
        RES_PLACED   = 2'd0,
        RES_NO_ROOM  = 2'd1,
        RES_REJECTED = 2'd2,
        RES_REMOVED  = 2'd3
    } status_t;

    typedef enum logic {
        OP_PLACE  = 1'b0,
        OP_REMOVE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_COLUMNS  = 2'd0,
        CFG_ROWS     = 2'd1,
        CFG_CATEGORY = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CORNER,
        ST_CK_RD,
        ST_CK_EV,
        ST_FILL,
        ST_RM_RD,
        ST_RM_EV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic    load;
        logic    sweep_next;
        logic    corner_next;
        logic    corner_row;
        logic    cell_init;
        logic    cell_next;
        logic    mem_rd;
        logic    mem_wr;
        logic    addr_sweep;
        logic    wr_zero;
        logic    set_res;
        status_t res;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic remove_op;
        logic rejected;
        logic row_fits;
        logic col_fits;
        logic cell_busy;
        logic cell_last;
        logic sweep_last;
        logic id_match;
    } stat_t;

    // Zero acts as one, anything above the maximum acts as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(logic [4:0] v, logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] ext;
        ext = {{(DIM_W-5){1'b0}}, v};
        if (ext == '0)
            return {{(DIM_W-1){1'b0}}, 1'b1};
        else if (ext > maxv)
            return maxv;
        else
            return ext;
    endfunction

endpackage

### rtl/gfp_ram.sv
// ----------------------------------------------------------------------------
// gfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

### rtl/gfp_datapath.sv
// ----------------------------------------------------------------------------
// gfp_datapath
// Configuration, request registers, scan counters, grid store and result.
// ----------------------------------------------------------------------------
module gfp_datapath #(
    parameter int MAX_COLUMNS = gfp_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = gfp_pkg::MAX_ROWS_DEF,
    parameter int ID_BITS     = gfp_pkg::ID_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic                  opcode,
    input  logic [7:0]            item_id,
    input  logic [4:0]            item_width,
    input  logic [4:0]            item_height,
    input  logic [7:0]            item_category,
    input  gfp_pkg::cmd_t         cmd,
    output gfp_pkg::stat_t        stat,
    output logic [1:0]            status,
    output logic [3:0]            place_column,
    output logic [3:0]            place_row
);

    localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
    localparam int AW         = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int DW         = gfp_pkg::DIM_W;

    logic [4:0]         cols_cfg_reg;
    logic [4:0]         rows_cfg_reg;
    logic [7:0]         mask_cfg_reg;
    logic               remove_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [DW-1:0]      w_reg, h_reg;
    logic [7:0]         cat_reg;
    logic [DW-1:0]      col_reg, row_reg;
    logic [AW:0]        base_reg;
    logic [DW-1:0]      cc_reg, cr_reg;
    logic [AW:0]        cbase_reg;
    logic [AW:0]        sweep_reg;
    gfp_pkg::status_t   res_reg;
    logic [1:0]         status_reg;
    logic [3:0]         pcol_reg, prow_reg;

    logic [DW-1:0]      cols, rows;
    logic [AW:0]        cols_ext;
    logic [AW:0]        cell_addr;
    logic [AW-1:0]      mem_addr;
    logic [ID_BITS-1:0] rd_data;
    logic [ID_BITS-1:0] wr_data;
    logic [ID_BITS+7:0] id_ext;
    logic [DW:0]        col_end, row_end, cc_inc, cr_inc, col_inc;
    logic               cell_row_end;

    assign cols     = gfp_pkg::clamp_dim(cols_cfg_reg, DW'(MAX_COLUMNS));
    assign rows     = gfp_pkg::clamp_dim(rows_cfg_reg, DW'(MAX_ROWS));
    assign cols_ext = (AW + 1)'(cols);
    assign id_ext   = {{ID_BITS{1'b0}}, item_id};

    assign col_end  = {1'b0, col_reg} + {1'b0, w_reg};
    assign row_end  = {1'b0, row_reg} + {1'b0, h_reg};
    assign cc_inc   = {1'b0, cc_reg} + 1'b1;
    assign cr_inc   = {1'b0, cr_reg} + 1'b1;
    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign cell_row_end = (cc_inc == col_end);

    assign cell_addr = cbase_reg + (AW + 1)'(cc_reg);
    assign mem_addr  = cmd.addr_sweep ? sweep_reg[AW-1:0] : cell_addr[AW-1:0];
    assign wr_data   = cmd.wr_zero ? '0 : id_reg;

    assign stat.remove_op  = (opcode == gfp_pkg::OP_REMOVE);
    assign stat.rejected   = (w_reg == '0) || (h_reg == '0) || (w_reg > cols)
                             || ((cat_reg & mask_cfg_reg) == 8'd0);
    assign stat.row_fits   = (row_end <= {1'b0, rows});
    assign stat.col_fits   = (col_end <= {1'b0, cols});
    assign stat.cell_busy  = (rd_data != '0);
    assign stat.cell_last  = cell_row_end && (cr_inc == {1'b0, h_reg});
    assign stat.sweep_last = (sweep_reg == (AW + 1)'(CELL_COUNT - 1));
    assign stat.id_match   = (rd_data == id_reg);

    gfp_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (CELL_COUNT)
    ) u_grid (
        .clk     (clk),
        .wr_en   (cmd.mem_wr),
        .wr_addr (mem_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.mem_rd),
        .rd_addr (mem_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= 5'd16;
            rows_cfg_reg <= 5'd16;
            mask_cfg_reg <= 8'hFF;
            sweep_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (gfp_pkg::cfg_index_t'(cfg_index))
                    gfp_pkg::CFG_COLUMNS:  cols_cfg_reg <= cfg_data[4:0];
                    gfp_pkg::CFG_ROWS:     rows_cfg_reg <= cfg_data[4:0];
                    gfp_pkg::CFG_CATEGORY: mask_cfg_reg <= cfg_data;
                    default:               ;
                endcase
            end
            if (cmd.load)
                sweep_reg <= '0;
            else if (cmd.sweep_next)
                sweep_reg <= sweep_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            remove_reg <= opcode;
            id_reg     <= id_ext[ID_BITS-1:0];
            w_reg      <= DW'(item_width);
            h_reg      <= DW'(item_height);
            cat_reg    <= item_category;
            col_reg    <= '0;
            row_reg    <= '0;
            base_reg   <= '0;
        end
        else if (cmd.corner_row || (cmd.corner_next && col_inc == {1'b0, cols}))
        begin
            col_reg  <= '0;
            row_reg  <= row_reg + 1'b1;
            base_reg <= base_reg + cols_ext;
        end
        else if (cmd.corner_next)
            col_reg <= col_inc[DW-1:0];

        if (cmd.cell_init)
        begin
            cc_reg    <= col_reg;
            cr_reg    <= '0;
            cbase_reg <= base_reg;
        end
        else if (cmd.cell_next)
        begin
            if (cell_row_end)
            begin
                cc_reg    <= col_reg;
                cr_reg    <= cr_inc[DW-1:0];
                cbase_reg <= cbase_reg + cols_ext;
            end
            else
                cc_reg <= cc_inc[DW-1:0];
        end

        if (cmd.set_res)
            res_reg <= cmd.res;

        if (cmd.out_load)
        begin
            status_reg <= res_reg;
            if (res_reg == gfp_pkg::RES_PLACED)
            begin
                pcol_reg <= col_reg[3:0];
                prow_reg <= row_reg[3:0];
            end
            else
            begin
                pcol_reg <= 4'd0;
                prow_reg <= 4'd0;
            end
        end
    end

    assign status       = status_reg;
    assign place_column = pcol_reg;
    assign place_row    = prow_reg;

    // cell accesses stay inside the store
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.mem_rd || cmd.mem_wr) && !cmd.addr_sweep) |-> cell_addr < (AW + 1)'(CELL_COUNT))
        else $error("cell address beyond the grid store");

    // rectangle walk never leaves the corner's column span
    a_cell_span: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_rd && !cmd.addr_sweep) |-> (cc_reg >= col_reg) && ({1'b0, cc_reg} < col_end))
        else $error("cell column outside the rectangle");

    // a remove result never reports a remove of a placed request
    a_remove_res: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.set_res && cmd.res == gfp_pkg::RES_REMOVED) |-> remove_reg)
        else $error("remove result on a place request");

endmodule

### rtl/gfp_ctrl.sv
// ----------------------------------------------------------------------------
// gfp_ctrl
// Sequencer for clearing pass, first-fit scan, fill, remove and result hand-off.
// ----------------------------------------------------------------------------
module gfp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  gfp_pkg::stat_t   stat,
    output gfp_pkg::cmd_t    cmd
);

    gfp_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gfp_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res        = gfp_pkg::RES_PLACED;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            gfp_pkg::ST_CLEAR:
            begin
                cmd.addr_sweep = 1'b1;
                cmd.wr_zero    = 1'b1;
                cmd.mem_wr     = 1'b1;
                cmd.sweep_next = 1'b1;
                if (stat.sweep_last)
                    state_next = gfp_pkg::ST_IDLE;
            end
            gfp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.remove_op ? gfp_pkg::ST_RM_RD : gfp_pkg::ST_CORNER;
                end
            end
            gfp_pkg::ST_CORNER:
            begin
                if (stat.rejected)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res     = gfp_pkg::RES_REJECTED;
                    state_next  = gfp_pkg::ST_DONE;
                end
                else if (!stat.row_fits)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res     = gfp_pkg::RES_NO_ROOM;
                    state_next  = gfp_pkg::ST_DONE;
                end
                else if (!stat.col_fits)
                    cmd.corner_row = 1'b1;
                else
                begin
                    cmd.cell_init = 1'b1;
                    state_next    = gfp_pkg::ST_CK_RD;
                end
            end
            gfp_pkg::ST_CK_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = gfp_pkg::ST_CK_EV;
            end
            gfp_pkg::ST_CK_EV:
            begin
                if (stat.cell_busy)
                begin
                    cmd.corner_next = 1'b1;
                    state_next      = gfp_pkg::ST_CORNER;
                end
                else if (stat.cell_last)
                begin
                    cmd.cell_init = 1'b1;
                    state_next    = gfp_pkg::ST_FILL;
                end
                else
                begin
                    cmd.cell_next = 1'b1;
                    state_next    = gfp_pkg::ST_CK_RD;
                end
            end
            gfp_pkg::ST_FILL:
            begin
                cmd.mem_wr    = 1'b1;
                cmd.cell_next = 1'b1;
                if (stat.cell_last)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res     = gfp_pkg::RES_PLACED;
                    state_next  = gfp_pkg::ST_DONE;
                end
            end
            gfp_pkg::ST_RM_RD:
            begin
                cmd.addr_sweep = 1'b1;
                cmd.mem_rd     = 1'b1;
                state_next     = gfp_pkg::ST_RM_EV;
            end
            gfp_pkg::ST_RM_EV:
            begin
                cmd.addr_sweep = 1'b1;
                cmd.wr_zero    = 1'b1;
                cmd.mem_wr     = stat.id_match;
                cmd.sweep_next = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.set_res = 1'b1;
                    cmd.res     = gfp_pkg::RES_REMOVED;
                    state_next  = gfp_pkg::ST_DONE;
                end
                else
                    state_next = gfp_pkg::ST_RM_RD;
            end
            gfp_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = gfp_pkg::ST_IDLE;
                end
            end
            default:
                state_next = gfp_pkg::ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.out_load)
        else $error("result register overwritten while held");

    // no result is raised during the clearing pass
    a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gfp_pkg::ST_CLEAR) |=> !out_valid_reg)
        else $error("result raised during clearing pass");

    // a loaded request always leaves idle
    a_load_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg != gfp_pkg::ST_IDLE))
        else $error("request loaded but sequencer stayed idle");

endmodule

### rtl/grid_first_fit_rect_placer_unit.sv
// ----------------------------------------------------------------------------
// grid_first_fit_rect_placer_unit
// First-fit rectangle placer over an owner-id grid, with remove by id.
// ----------------------------------------------------------------------------
// Remove reads each of the CELL_COUNT cells in turn and clears every cell
// that holds the id. Place tries corners in order, moving to the next row
// when the rectangle overruns the columns, and reads the candidate's cells
// until one is occupied; if none is, it fills them. A rejected request goes
// straight to the result. Flow: one item in flight; the grid RAM walk sets
// the rate, and a new transfer is taken the cycle after the result is loaded.
// Reset: a clearing pass writes zero to all CELL_COUNT cells, one a cycle;
// in_ready stays low until the pass ends. Config writes are taken.
// ----------------------------------------------------------------------------
module grid_first_fit_rect_placer_unit #(
    parameter int MAX_COLUMNS = gfp_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = gfp_pkg::MAX_ROWS_DEF,
    parameter int ID_BITS     = gfp_pkg::ID_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // configuration write port
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    // request channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    input  logic [7:0] item_id,
    input  logic [4:0] item_width,
    input  logic [4:0] item_height,
    input  logic [7:0] item_category,
    // result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [3:0] place_column,
    output logic [3:0] place_row
);

    gfp_pkg::cmd_t  cmd;
    gfp_pkg::stat_t stat;

    // sequencer: owns the state and the result-valid flag
    gfp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: config, counters, grid RAM and result register
    gfp_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .item_id       (item_id),
        .item_width    (item_width),
        .item_height   (item_height),
        .item_category (item_category),
        .cmd           (cmd),
        .stat          (stat),
        .status        (status),
        .place_column  (place_column),
        .place_row     (place_row)
    );

    // anything but a placement reports the origin
    a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != gfp_pkg::RES_PLACED) |-> (place_column == 4'd0 && place_row == 4'd0))
        else $error("position reported on a non-placed result");

endmodule
